// ===== hw/rtl/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Command passed from the front to the compression engine.
  typedef enum logic [1:0] {
    CMD_BLOCK = 2'd0,
    CMD_FINAL = 2'd1
  } cmd_e;

  typedef struct packed {
    cmd_e          cmd;
    logic [511:0]  block;
  } job_t;

  localparam int unsigned JobQDepth = 2;

  localparam logic [255:0] HashInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hw/rtl/sha_front.sv =====
// Byte packer and padder: builds 512-bit blocks and queues them as jobs.
module sha_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  sha_pkg::in_item_t in_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output sha_pkg::job_t    job_o
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_LEN  = 4'b0100,
    S_WAIT = 4'b1000
  } state_e;

  state_e       state_q, state_d;
  logic [511:0] buf_q, buf_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  total_q, total_d;
  logic         jv_q, jv_d;
  job_t         job_q, job_d;
  logic         byte_nxt;

  assign job_valid_o = jv_q;
  assign job_o       = job_q;
  assign full        = (state_q != S_IDLE) || jv_q;

  function automatic logic [511:0] put_byte(input logic [511:0] b, input logic [5:0] pos,
                                            input logic [7:0] v);
    logic [511:0] r;
    r = b;
    r[511 - 8*pos -: 8] = v;
    return r;
  endfunction

  // Clear bytes at or after pos.
  function automatic logic [511:0] clr_tail(input logic [511:0] b, input logic [6:0] pos);
    logic [511:0] m;
    m = (pos == 7'd64) ? '1 : ~({512{1'b1}} >> (8*pos));
    return b & m;
  endfunction

  always_comb begin
    state_d  = state_q;
    buf_d    = buf_q;
    fill_d   = fill_q;
    total_d  = total_q;
    jv_d     = jv_q && !job_ready_i;
    job_d    = job_q;
    byte_nxt = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (push && !full) begin
          if (in_i.byte_valid) begin
            buf_d   = put_byte(buf_q, fill_q, in_i.data_byte);
            fill_d  = fill_q + 6'd1;
            total_d = total_q + 61'd1;
            if (fill_q == 6'd63) begin
              jv_d      = 1'b1;
              job_d.cmd = CMD_BLOCK;
              job_d.block = buf_d;
              byte_nxt  = 1'b1;
            end
          end
          if (in_i.end_of_message) state_d = byte_nxt ? S_WAIT : S_PAD;
        end
      end
      S_WAIT: if (!jv_q) state_d = S_PAD;
      S_PAD: begin
        buf_d  = clr_tail(put_byte(buf_q, fill_q, PadByte), {1'b0, fill_q} + 7'd1);
        fill_d = fill_q + 6'd1;
        if (fill_q >= LenOffset) begin
          jv_d        = 1'b1;
          job_d.cmd   = CMD_BLOCK;
          job_d.block = buf_d;
          buf_d       = '0;
        end
        state_d = S_LEN;
      end
      S_LEN: begin
        if (!jv_q) begin
          jv_d        = 1'b1;
          job_d.cmd   = CMD_FINAL;
          job_d.block = {buf_q[511:64], total_q, 3'b000};
          fill_d      = '0;
          total_d     = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      jv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      jv_q    <= jv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    job_q <= job_d;
  end
endmodule

// ===== hw/rtl/sha_jobq.sv =====
// Short job queue between the packer and the compression engine.
module sha_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  sha_pkg::job_t wr_job_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output sha_pkg::job_t rd_job_o
);
  import sha_pkg::*;

  job_t        mem_q [JobQDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        wr, rd;

  assign wr_ready_o = cnt_q != 2'(JobQDepth);
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_job_o   = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) if (wr) mem_q[wp_q] <= wr_job_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// ===== hw/rtl/sha_core.sv =====
// Compression engine: one round per cycle, digest word output register.
module sha_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  sha_pkg::job_t     job_i,
  output logic              empty,
  input  logic              pop,
  output sha_pkg::out_item_t out_o
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_RUN  = 4'b0010,
    C_ADD  = 4'b0100,
    C_OUT  = 4'b1000
  } state_e;

  state_e        state_q;
  logic [255:0]  h_q;
  logic [31:0]   v_q [8];
  logic [511:0]  w_q;
  logic [5:0]    rnd_q;
  logic          fin_q;
  logic [2:0]    idx_q;
  logic [31:0]   w0, w1, w9, w14, wn, t1, t2, s0, s1;
  logic [255:0]  sum;

  assign w0  = w_q[511:480];
  assign w1  = w_q[479:448];
  assign w9  = w_q[223:192];
  assign w14 = w_q[63:32];
  assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign wn  = w0 + s0 + w9 + s1;
  assign t1  = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
             + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + w0;
  assign t2  = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
             + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    for (int j = 0; j < 8; j++)
      sum[255 - 32*j -: 32] = h_q[255 - 32*j -: 32] + v_q[j];
  end

  assign job_ready_o = state_q == C_IDLE;
  assign empty       = state_q != C_OUT;
  assign out_o.digest_word = h_q[255 - 32*idx_q -: 32];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = idx_q == 3'd7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      h_q     <= HashInit;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        C_IDLE: if (job_valid_i) begin
          fin_q   <= job_i.cmd == CMD_FINAL;
          rnd_q   <= '0;
          state_q <= C_RUN;
        end
        C_RUN: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= C_ADD;
        end
        C_ADD: begin
          h_q   <= sum;
          idx_q <= '0;
          state_q <= fin_q ? C_OUT : C_IDLE;
        end
        C_OUT: if (pop) begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            h_q     <= HashInit;
            state_q <= C_IDLE;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && job_valid_i) begin
      w_q <= job_i.block;
      for (int j = 0; j < 8; j++) v_q[j] <= h_q[255 - 32*j -: 32];
    end else if (state_q == C_RUN) begin
      w_q <= {w_q[479:0], wn};
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end
endmodule

// ===== hw/rtl/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher: one byte per request, eight digest words per message.
// Bytes are taken one per cycle while full is low; each full block passes through the round engine
// as a load, 64 rounds and a chaining add, and the packer can fill more blocks while the job queue has room.
// End of message adds padding plus one or two blocks, then 8 pops.
// Reset is asynchronous active low: chaining words return to the initial hash,
// counters and queues clear; block and schedule data are not reset.
module sha256_stream_hasher_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  sha_pkg::in_item_t  in_i,
  output logic               empty,
  input  logic               pop,
  output sha_pkg::out_item_t out_o
);
  import sha_pkg::*;

  logic f_valid, f_ready, c_valid, c_ready;
  job_t f_job, c_job;

  sha_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_i,
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  sha_jobq u_jobq (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_job_i(f_job),
    .rd_valid_o(c_valid), .rd_ready_i(c_ready), .rd_job_o(c_job)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .job_valid_i(c_valid), .job_ready_o(c_ready), .job_i(c_job),
    .empty, .pop, .out_o
  );
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the SHA-256 stream hasher: random byte streams checked against a software hash.
module tb_top;
  import sha_pkg::*;

  // Software SHA-256 that tracks the hasher's message state and queues digest words.
  class digest_board;
    logic [31:0] chain[8];
    logic [7:0]  blk[64];
    int unsigned fill;
    logic [60:0] total;
    out_item_t   pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      restart();
      errors = 0;
      checked = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = HashInit[255 - 32*i -: 32];
      fill = 0;
      total = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int j = 0; j < 8; j++) v[j] = chain[j];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int j = 7; j > 0; j--) v[j] = v[j-1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) chain[j] += v[j];
    endfunction

    function void note_request(in_item_t it);
      logic [63:0] bits;
      out_item_t o;
      if (it.byte_valid) begin
        blk[fill] = it.data_byte;
        fill++;
        total = total + 61'd1;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!it.end_of_message) return;
      bits = {total, 3'b000};
      blk[fill] = PadByte;
      fill++;
      if (fill > LenOffset) begin
        for (int i = fill; i < 64; i++) blk[i] = 8'h00;
        compress();
        fill = 0;
      end
      for (int i = fill; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = chain[i];
        o.word_index = i[2:0];
        o.last_word = (i == 7);
        pending.push_back(o);
      end
      restart();
    endfunction

    function void check_word(out_item_t got);
      out_item_t exp_w;
      if (pending.size() == 0) begin
        $error("digest word with nothing pending: %h", got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (got.digest_word !== exp_w.digest_word) begin
        $error("digest_word exp %h got %h", exp_w.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== exp_w.word_index) begin
        $error("word_index exp %0d got %0d", exp_w.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== exp_w.last_word) begin
        $error("last_word exp %0b got %0b", exp_w.last_word, got.last_word);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_o;

  digest_board board = new();
  int unsigned cycles = 0;
  int unsigned messages = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  bit pop_steady = 1'b0;

  sha256_stream_hasher_top dut (
    .clk_i, .rst_ni, .push, .full, .in_i, .empty, .pop, .out_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: alternates between always-ready stretches and random stalls.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && pop && !empty) board.check_word(out_o);
    if ($urandom_range(0, 63) == 0) pop_steady <= ~pop_steady;
    pop <= pop_steady ? 1'b1 : ($urandom_range(0, 2) != 0);
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one request; holds push until the block accepts it, with burst gaps in between.
  task automatic send_request(logic [7:0] b, logic v, logic e);
    in_item_t it;
    it.data_byte = b;
    it.byte_valid = v;
    it.end_of_message = e;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
    end
    burst_left--;
    push <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (full);
    board.note_request(it);
    if (v) bytes_sent++;
    if (e) messages++;
  endtask

  task automatic send_message(int unsigned len, bit with_last_byte, bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      if (with_last_byte && i == len - 1) send_request(8'($urandom), 1'b1, 1'b1);
      else send_request(8'($urandom), 1'b1, 1'b0);
    end
    if (!with_last_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, repeated end, extreme bytes, idle item.
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h7f, 1'b1, 1'b1);
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'haa, 1'b0, 1'b1);
    // Padding spills into a second block; then a byte that completes a block ends the message.
    send_message(56, 1'b0, 1'b0);
    send_message(64, 1'b1, 1'b0);
    push <= 1'b0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (300) @(posedge clk_i);
    $display("sent %0d bytes in %0d messages, checked %0d digest words",
             bytes_sent, messages, board.checked);
    $display("covered empty and short messages, pad spill and a block-ending last byte");
    if (board.errors == 0 && board.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
